// ===== hw/rtl/hkrd_pkg.sv =====
// Shared types and constants for the HID keyboard report diff block.
package hkrd_pkg;

	// Report layout.
	localparam int SLOT_COUNT = 6;
	localparam int MOD_BITS   = 8;
	localparam int CODE_W     = 8;

	// Event slots per report: modifier changes, presses, releases.
	localparam int EVT_COUNT     = MOD_BITS + 2 * SLOT_COUNT;
	localparam int EVT_IDX_W     = $clog2(EVT_COUNT);
	localparam int PRESS_BASE    = MOD_BITS;
	localparam int RELEASE_BASE  = MOD_BITS + SLOT_COUNT;

	// Usage code of modifier bit 0.
	localparam logic [CODE_W-1:0] MOD_BASE = 8'hE0;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef logic [SLOT_COUNT-1:0][CODE_W-1:0] key_array_t;

	// One classified report: which events fire, plus the codes they need.
	typedef struct packed {
		logic [EVT_COUNT-1:0] mask;
		logic [MOD_BITS-1:0]  mods;
		key_array_t           new_keys;
		key_array_t           old_keys;
	} diff_t;

	// Handshake between the queue and its neighbors: push from the front, pop from the back.
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_sts_t;

endpackage

// ===== hw/rtl/hkrd_front.sv =====
// Front end: accepts reports, diffs them against the stored report, builds event masks.
module hkrd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rpt_valid,
	output logic                          rpt_stall,
	input  logic                          report_valid,
	input  logic [7:0]                    modifier_bits,
	input  hkrd_pkg::key_array_t          keys,
	input  logic                          q_full,
	output logic                          push,
	output hkrd_pkg::diff_t               push_data
);
	import hkrd_pkg::*;

	logic [MOD_BITS-1:0] prev_mods_q;
	key_array_t          prev_keys_q;
	logic [SLOT_COUNT-1:0] press;
	logic [SLOT_COUNT-1:0] release_hit;
	logic                  accept;

	assign rpt_stall = q_full;
	assign accept    = rpt_valid && !rpt_stall;

	// Presses are new keys missing from the old slots; releases the reverse.
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			press[i]       = (keys[i] != '0);
			release_hit[i] = (prev_keys_q[i] != '0);
			for (int j = 0; j < SLOT_COUNT; j++) begin
				if (keys[i] == prev_keys_q[j]) begin
					press[i] = 1'b0;
				end
				if (prev_keys_q[i] == keys[j]) begin
					release_hit[i] = 1'b0;
				end
			end
		end
	end

	// Pack the classified report for the back end.
	always_comb begin
		push_data.mask     = {release_hit, press, modifier_bits ^ prev_mods_q};
		push_data.mods     = modifier_bits;
		push_data.new_keys = keys;
		push_data.old_keys = prev_keys_q;
	end

	// Only valid reports that change something produce events.
	assign push = accept && report_valid && (push_data.mask != '0);

	// Stored report; an invalid report leaves it alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			prev_keys_q <= '0;
		end else if (accept && report_valid) begin
			prev_mods_q <= modifier_bits;
			prev_keys_q <= keys;
		end
	end

	// An invalid report must not disturb the stored state.
	a_invalid_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !report_valid |=> $stable(prev_mods_q) && $stable(prev_keys_q))
		else $error("invalid report changed stored state");

	// Nothing is queued while the queue is full.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push while queue full");

	// A report identical to the stored one queues nothing.
	a_same_report_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (modifier_bits == prev_mods_q) && (keys == prev_keys_q) |-> !push)
		else $error("unchanged report produced events");

endmodule

// ===== hw/rtl/hkrd_queue.sv =====
// Small circular queue of classified reports between front and back.
module hkrd_queue #(
	parameter int DEPTH = hkrd_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hkrd_pkg::queue_ctl_t   ctl,
	input  hkrd_pkg::diff_t        push_data,
	output hkrd_pkg::diff_t        head,
	output hkrd_pkg::queue_sts_t   sts
);
	import hkrd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	diff_t           mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign sts.full      = (count_q == FULL_CNT);
	assign sts.not_empty = (count_q != '0);
	assign head          = mem_q[rd_ptr_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Pops only from a filled queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> sts.not_empty)
		else $error("pop from empty queue");

	// Fill count never exceeds the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count overflow");

	// A push alone raises the count by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push && !ctl.pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow push");

endmodule

// ===== hw/rtl/hkrd_back.sv =====
// Back end: walks each event mask lowest bit first and drives one event per beat.
module hkrd_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hkrd_pkg::diff_t        head,
	input  logic                   q_not_empty,
	output logic                   pop,
	output logic                   evt_valid,
	input  logic                   evt_stall,
	output logic [7:0]             event_code,
	output logic                   event_pressed,
	output logic                   event_last
);
	import hkrd_pkg::*;

	diff_t                 work_q;
	logic                  out_valid_q;
	logic [CODE_W-1:0]     code_q;
	logic                  pressed_q;
	logic                  last_q;

	logic                  advance;
	logic                  use_head;
	logic                  have_evt;
	diff_t                 src;
	logic [EVT_IDX_W-1:0]  idx;
	logic [EVT_IDX_W-1:0]  slot_off;
	logic [EVT_COUNT-1:0]  rest;
	logic [CODE_W-1:0]     code_d;
	logic                  pressed_d;

	// Output register frees as soon as its beat is taken.
	assign advance  = !out_valid_q || !evt_stall;
	assign use_head = (work_q.mask == '0);
	assign src      = use_head ? head : work_q;
	assign have_evt = use_head ? q_not_empty : 1'b1;
	assign pop      = advance && use_head && q_not_empty;

	// Lowest pending event wins.
	always_comb begin
		idx = '0;
		for (int i = EVT_COUNT - 1; i >= 0; i--) begin
			if (src.mask[i]) begin
				idx = EVT_IDX_W'(i);
			end
		end
	end

	assign rest = src.mask & ~(EVT_COUNT'(1) << idx);

	// Event code and level for the chosen position.
	always_comb begin
		slot_off = '0;
		if (idx < EVT_IDX_W'(PRESS_BASE)) begin
			code_d    = MOD_BASE + CODE_W'(idx);
			pressed_d = src.mods[idx[$clog2(MOD_BITS)-1:0]];
		end else if (idx < EVT_IDX_W'(RELEASE_BASE)) begin
			slot_off  = idx - EVT_IDX_W'(PRESS_BASE);
			code_d    = src.new_keys[slot_off[$clog2(SLOT_COUNT)-1:0]];
			pressed_d = 1'b1;
		end else begin
			slot_off  = idx - EVT_IDX_W'(RELEASE_BASE);
			code_d    = src.old_keys[slot_off[$clog2(SLOT_COUNT)-1:0]];
			pressed_d = 1'b0;
		end
	end

	// Work register and output beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= have_evt;
			if (have_evt) begin
				work_q.mask     <= rest;
				work_q.mods     <= src.mods;
				work_q.new_keys <= src.new_keys;
				work_q.old_keys <= src.old_keys;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (advance && have_evt) begin
			code_q    <= code_d;
			pressed_q <= pressed_d;
			last_q    <= (rest == '0);
		end
	end

	assign evt_valid     = out_valid_q;
	assign event_code    = code_q;
	assign event_pressed = pressed_q;
	assign event_last    = last_q;

	// Pending work always sits behind a beat on the output.
	a_pending_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		work_q.mask != '0 |-> out_valid_q)
		else $error("pending events without an output beat");

	// The last beat of a report leaves nothing pending.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> work_q.mask == '0)
		else $error("events pending after last beat");

	// A new report is only taken once the current one is drained.
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> work_q.mask == '0)
		else $error("queue popped while events pending");

endmodule

// ===== hw/rtl/hid_keyboard_report_diff_top.sv =====
// Top level of the HID boot-keyboard report to key event converter.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  report  | rpt_valid, rpt_stall | report_valid, modifier_bits, key_slot_0..5
//  event   | evt_valid, evt_stall | event_code, event_pressed, event_last
//
// A report is classified in the cycle it is accepted and queued (QUEUE_DEPTH entries).
// The back end sends one event beat per cycle while evt_stall is low, so a report with N
// events gives N beats on the event channel, up to 20; consecutive reports follow with no gap.
// The report side stalls only while the queue is full; invalid or unchanged reports
// are taken and produce no beats. Reset clears the stored report to zero.
module hid_keyboard_report_diff_top #(
	parameter int QUEUE_DEPTH = hkrd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rpt_valid,
	output logic       rpt_stall,
	input  logic       report_valid,
	input  logic [7:0] modifier_bits,
	input  logic [7:0] key_slot_0,
	input  logic [7:0] key_slot_1,
	input  logic [7:0] key_slot_2,
	input  logic [7:0] key_slot_3,
	input  logic [7:0] key_slot_4,
	input  logic [7:0] key_slot_5,
	output logic       evt_valid,
	input  logic       evt_stall,
	output logic [7:0] event_code,
	output logic       event_pressed,
	output logic       event_last
);
	import hkrd_pkg::*;

	key_array_t  keys;
	diff_t       push_data;
	diff_t       head;
	queue_ctl_t  q_ctl;
	queue_sts_t  q_sts;

	assign keys = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0};

	// Report classification.
	hkrd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.rpt_valid     (rpt_valid),
		.rpt_stall     (rpt_stall),
		.report_valid  (report_valid),
		.modifier_bits (modifier_bits),
		.keys          (keys),
		.q_full        (q_sts.full),
		.push          (q_ctl.push),
		.push_data     (push_data)
	);

	// Decoupling queue.
	hkrd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.push_data (push_data),
		.head      (head),
		.sts       (q_sts)
	);

	// Event serializer.
	hkrd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_not_empty   (q_sts.not_empty),
		.pop           (q_ctl.pop),
		.evt_valid     (evt_valid),
		.evt_stall     (evt_stall),
		.event_code    (event_code),
		.event_pressed (event_pressed),
		.event_last    (event_last)
	);

endmodule
